/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// Taylor sine series package
// Widths, defaults and the result record shared by the core and the top level.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Port field widths.
   localparam int ANGLE_W = 16;
   localparam int ORDER_W = 5;
   localparam int VALUE_W = 32;

   // Default highest order of the series.
   localparam int MAX_ORDER_DEF = 23;

   // Fraction bits of the angle; also the shift from Q.32 to Q.20.
   localparam int FRAC_IN = 12;

   // Term magnitude in Q.32. The largest term is 8^8/8! < 2^9, so 41 bits hold it.
   localparam int PW     = 41;
   localparam int P_LO_W = 21;
   localparam int P_HI_W = PW - P_LO_W;

   // Angle magnitude, up to 2^15.
   localparam int MAG_W = ANGLE_W;

   // Multiplier result and full product of one term step.
   localparam int MUL_W = P_LO_W + MAG_W;
   localparam int NW    = PW + MAG_W;

   // Divider dividend, padded to a whole number of digit steps.
   localparam int DIV_BITS   = 8;
   localparam int QW         = 48;
   localparam int DIV_CYCLES = QW / DIV_BITS;
   localparam int DCW        = $clog2(DIV_CYCLES);

   // Signed accumulator; every partial sum stays below e^8 * 2^32 < 2^44.
   localparam int ACC_W = 46;

   // Rounded magnitude in Q.20 before clamping.
   localparam int R_W = ACC_W - FRAC_IN + 1;

   // Result record offered by the core.
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               saturated;
   } tss_result_type;

endpackage

/* rtl/tss_core.sv */
// ----------------------------------------------------------------------------
// Taylor sine series core
// Sequencer around one shared multiplier and one digit-serial divider that
// builds the terms x^k/k! one after another and sums the odd ones.
// ----------------------------------------------------------------------------
module tss_core #(
   parameter int MAX_ORDER = tss_pkg::MAX_ORDER_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             idle,
   input  logic signed [tss_pkg::ANGLE_W-1:0] angle,
   input  logic [tss_pkg::ORDER_W-1:0]      max_order,
   output tss_pkg::tss_result_type          res,
   input  logic                             res_ready
);
   import tss_pkg::*;

   localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER + 1) : 1;
   localparam int CW = (KW > ORDER_W) ? KW : ORDER_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_SUM,
      S_DIV,
      S_ACC,
      S_FIN1,
      S_FIN2
   } state_type;

   state_type             state_ff;
   logic [KW-1:0]         k_ff;
   logic [KW-1:0]         order_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg_ff;
   logic [PW-1:0]         p_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [MUL_W-1:0]      prodlo_ff;
   logic [MUL_W-1:0]      prodhi_ff;
   logic [QW-1:0]         dq_ff;
   logic [KW-1:0]         rem_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic [R_W-1:0]        r_ff;
   logic                  rneg_ff;

   logic [CW-1:0]         ord_ext;
   logic [KW-1:0]         ord_clamped;
   logic [MAG_W-1:0]      mag_in;
   logic [P_LO_W-1:0]     mul_a;
   logic [MUL_W-1:0]      mul_out;
   logic [NW-1:0]         sum_n;
   logic [QW-1:0]         div_dq_in;
   logic [KW-1:0]         div_rem_in;
   logic [KW:0]           trial;
   logic [KW:0]           k_ext;
   logic [ACC_W-1:0]      mag_acc;
   logic [ACC_W:0]        round_sum;
   logic                  acc_neg;
   logic [VALUE_W-1:0]    fin_value;
   logic                  fin_sat;

   // Clamp the requested order and take the angle magnitude.
   assign ord_ext     = CW'(max_order);
   assign ord_clamped = (ord_ext > CW'(MAX_ORDER)) ? KW'(MAX_ORDER) : KW'(ord_ext);
   assign mag_in      = angle[ANGLE_W-1] ? (MAG_W'(0) - MAG_W'(angle)) : MAG_W'(angle);

   // Shared multiplier: low half of the term, then the high half.
   assign mul_a   = (state_ff == S_MUL_LO) ? p_ff[P_LO_W-1:0]
                                           : P_LO_W'(p_ff[PW-1:P_LO_W]);
   assign mul_out = MUL_W'(mul_a) * MUL_W'(mag_ff);

   // Full product plus the rounding offset 2048*k, before the shift by 12.
   assign sum_n = {prodhi_ff[NW-P_LO_W-1:0], {P_LO_W{1'b0}}}
                + NW'(prodlo_ff)
                + NW'({k_ff, {(FRAC_IN-1){1'b0}}});

   // Divider by k: several restoring digit steps per cycle on a narrow remainder.
   always_comb begin
      div_dq_in  = dq_ff;
      div_rem_in = rem_ff;
      trial      = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial     = {div_rem_in, div_dq_in[QW-1]};
         div_dq_in = {div_dq_in[QW-2:0], 1'b0};
         if (trial >= {1'b0, k_ff}) begin
            trial        = trial - {1'b0, k_ff};
            div_dq_in[0] = 1'b1;
         end
         div_rem_in = trial[KW-1:0];
      end
   end

   // Odd term k is subtracted when bit 1 of k is set (k = 3, 7, 11, ...).
   assign k_ext = {1'b0, k_ff};

   // Final rounding of the accumulator magnitude to Q.20.
   assign acc_neg   = acc_ff[ACC_W-1];
   assign mag_acc   = acc_neg ? (ACC_W'(0) - ACC_W'(acc_ff)) : ACC_W'(acc_ff);
   assign round_sum = (ACC_W+1)'(mag_acc) + (ACC_W+1)'(1 << (FRAC_IN - 1));

   // Sign and clamp to the 32-bit output range.
   always_comb begin
      fin_sat   = 1'b0;
      fin_value = r_ff[VALUE_W-1:0];
      if (rneg_ff) begin
         if (r_ff > (R_W'(1) << (VALUE_W - 1))) begin
            fin_sat   = 1'b1;
            fin_value = {1'b1, {(VALUE_W-1){1'b0}}};
         end else begin
            fin_value = VALUE_W'(0) - r_ff[VALUE_W-1:0];
         end
      end else if (r_ff > R_W'({1'b0, {(VALUE_W-1){1'b1}}})) begin
         fin_sat   = 1'b1;
         fin_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   assign idle          = (state_ff == S_IDLE);
   assign res.valid     = (state_ff == S_FIN2);
   assign res.value     = fin_value;
   assign res.saturated = fin_sat;

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  k_ff     <= KW'(1);
                  order_ff <= ord_clamped;
                  mag_ff   <= mag_in;
                  neg_ff   <= angle[ANGLE_W-1];
                  p_ff     <= PW'(64'h1_0000_0000);
                  acc_ff   <= '0;
                  state_ff <= (ord_clamped == '0) ? S_FIN1 : S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               prodlo_ff <= mul_out;
               state_ff  <= S_MUL_HI;
            end
            S_MUL_HI: begin
               prodhi_ff <= mul_out;
               state_ff  <= S_SUM;
            end
            S_SUM: begin
               dq_ff    <= QW'(sum_n[NW-1:FRAC_IN]);
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               dq_ff   <= div_dq_in;
               rem_ff  <= div_rem_in;
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(DIV_CYCLES - 1)) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               p_ff <= dq_ff[PW-1:0];
               if (k_ff[0]) begin
                  if (k_ext[1]) begin
                     acc_ff <= acc_ff - ACC_W'(dq_ff[PW-1:0]);
                  end else begin
                     acc_ff <= acc_ff + ACC_W'(dq_ff[PW-1:0]);
                  end
               end
               if (k_ff == order_ff) begin
                  state_ff <= S_FIN1;
               end else begin
                  k_ff     <= k_ff + KW'(1);
                  state_ff <= S_MUL_LO;
               end
            end
            S_FIN1: begin
               r_ff     <= round_sum[ACC_W:FRAC_IN];
               rneg_ff  <= (acc_ff != '0) && (acc_neg != neg_ff);
               state_ff <= S_FIN2;
            end
            S_FIN2: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // The term counter never runs past the clamped order.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && order_ff != '0) |-> (k_ff <= order_ff))
      else $error("term counter passed the order");

   // Every term fits the term register once the division is done.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (dq_ff[QW-1:PW] == '0))
      else $error("term overflowed its width");

   // The divider remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (rem_ff < k_ff))
      else $error("divider remainder not reduced");
`endif

endmodule

/* rtl/taylor_sine_series.sv */
// Each request computes the terms up to order n = min(max_order, MAX_ORDER).
// One request is worked on at a time; each term takes two passes through the one
// multiplier, an add, a division by k in digit steps of eight quotient bits and an accumulate.
// The block is busy from request to hand-off; the output register can hold a result meanwhile.
// Reset is synchronous and active high; it idles the sequencer and empties the output.
// ----------------------------------------------------------------------------
// Taylor sine series
// Truncated Taylor sum of sin(x) for a Q3.12 angle, rounded and saturated to Q11.20.
// ----------------------------------------------------------------------------
module taylor_sine_series #(
   parameter int MAX_ORDER = tss_pkg::MAX_ORDER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [tss_pkg::ANGLE_W-1:0] req_angle,
   input  logic [tss_pkg::ORDER_W-1:0]        req_max_order,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tss_pkg::VALUE_W-1:0] rsp_sine_value,
   output logic                               rsp_saturated
);
   import tss_pkg::*;

   tss_result_type     core_res;
   logic               core_idle;
   logic               core_res_ready;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_sat_ff;

   // Compute core.
   tss_core #(
      .MAX_ORDER (MAX_ORDER)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid),
      .idle      (core_idle),
      .angle     (req_angle),
      .max_order (req_max_order),
      .res       (core_res),
      .res_ready (core_res_ready)
   );

   assign req_ready      = core_idle;
   assign core_res_ready = !rsp_valid_ff || rsp_ready;

   // Output register: loads a result beat whenever it is empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_res_ready) begin
         rsp_valid_ff <= core_res.valid;
         if (core_res.valid) begin
            rsp_value_ff <= core_res.value;
            rsp_sat_ff   <= core_res.saturated;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

`ifndef SYNTHESIS
   // A saturated result sits at one of the two range limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_value_ff == {1'b1, {(VALUE_W-1){1'b0}}} ||
          rsp_value_ff == {1'b0, {(VALUE_W-1){1'b1}}}))
      else $error("saturated result not at a range limit");

   // After a request beat the block stays busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready after a request beat");

   // The output only fills from a result the core offered.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(core_res.valid))
      else $error("response without a core result");
`endif

endmodule
